FILE: design/bvh_pkg.sv
// Shared types, constants and helper functions for the box vs height patch collision block.
package bvh_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 32 + FRAC_BITS;   // ratio magnitude width, one divider cell per bit
    localparam int DIV_STEPS = Q_W;
    localparam int LERP_LAT  = 4;
    localparam int PROD_W    = 33 + Q_W;
    localparam int SAT_W     = 40;

    localparam logic [2:0] REG_MIN_X  = 3'd0;
    localparam logic [2:0] REG_MIN_Y  = 3'd1;
    localparam logic [2:0] REG_MAX_X  = 3'd2;
    localparam logic [2:0] REG_MAX_Y  = 3'd3;
    localparam logic [2:0] REG_H_LL   = 3'd4;
    localparam logic [2:0] REG_H_HL   = 3'd5;
    localparam logic [2:0] REG_H_LH   = 3'd6;
    localparam logic [2:0] REG_H_HH   = 3'd7;

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        extent_x;
        logic [30:0]        extent_y;
        logic [30:0]        extent_z;
        logic               uniform_size;
    } query_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] floor_height;
        logic               inside_xy;
    } result_t;

    // restoring division state of one axis
    typedef struct packed {
        logic [31:0]    rem;
        logic [Q_W-1:0] nq;
        logic [31:0]    div;
        logic           neg;
        logic           zero;
    } div_t;

    typedef struct packed {
        logic               valid;
        div_t               ax;
        div_t               ay;
        logic signed [31:0] cz;
        logic [30:0]        ez;
        logic               in_xy;
    } pl_t;

    typedef struct packed {
        logic               valid;
        logic [Q_W-1:0]     rx_mag;
        logic               rx_neg;
        logic signed [31:0] cz;
        logic [30:0]        ez;
        logic               in_xy;
    } tag_t;

    function automatic div_t div_step(input div_t s);
        div_t        r;
        logic [32:0] trial;
        logic [32:0] dv;
        logic        ge;
        logic [32:0] nr;
        r     = s;
        trial = {s.rem, s.nq[Q_W-1]};
        dv    = {1'b0, s.div};
        ge    = (trial >= dv);
        nr    = ge ? (trial - dv) : trial;
        r.rem = nr[31:0];
        r.nq  = {s.nq[Q_W-2:0], ge};
        return r;
    endfunction

    function automatic logic signed [33:0] twice(input logic signed [31:0] v);
        return {v[31], v, 1'b0};
    endfunction

    function automatic logic signed [33:0] ext_extent(input logic [30:0] e);
        return {3'b000, e};
    endfunction

endpackage

FILE: design/bvh_div_cell.sv
// One pipelined restoring-division cell: one quotient bit per axis per cycle if en.
module bvh_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  bvh_pkg::pl_t  pin,
    output bvh_pkg::pl_t  pout
);

    bvh_pkg::pl_t stage_reg;
    bvh_pkg::pl_t stage_next;

    always_comb
    begin
        stage_next    = pin;
        stage_next.ax = bvh_pkg::div_step(pin.ax);
        stage_next.ay = bvh_pkg::div_step(pin.ay);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign pout = stage_reg;

endmodule

FILE: design/bvh_lerp.sv
// Four-stage saturating fixed-point linear interpolation a + (b - a) * r.
module bvh_lerp (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [31:0]          a,
    input  logic signed [31:0]          b,
    input  logic [bvh_pkg::Q_W-1:0]     r_mag,
    input  logic                        r_neg,
    output logic signed [31:0]          y
);

    localparam int QW = bvh_pkg::Q_W;
    localparam int PW = bvh_pkg::PROD_W;
    localparam int FB = bvh_pkg::FRAC_BITS;
    localparam int SW = bvh_pkg::SAT_W;

    // stage 0
    logic signed [32:0] diff;
    logic [32:0]        ua_next;
    logic [32:0]        ua_reg;
    logic [QW-1:0]      ub0_reg;
    logic               neg0_reg;
    logic               zero0_reg;
    logic signed [31:0] a0_reg;

    // stage 1
    logic [64:0]        plo_reg;
    logic [32+FB:0]     phi_reg;
    logic               neg1_reg;
    logic               zero1_reg;
    logic signed [31:0] a1_reg;

    // stage 2
    logic [PW-1:0]      prod;
    logic [SW-1:0]      qv_reg;
    logic               rem_reg;
    logic               ovf_reg;
    logic               neg2_reg;
    logic               zero2_reg;
    logic signed [31:0] a2_reg;

    // stage 3
    logic [SW:0]        qadj;
    logic signed [42:0] qs;
    logic signed [42:0] sum;
    logic signed [31:0] y_next;
    logic signed [31:0] y_reg;

    assign diff    = {b[31], b} - {a[31], a};
    assign ua_next = diff[32] ? 33'(-diff) : diff;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg    <= ua_next;
            ub0_reg   <= r_mag;
            neg0_reg  <= diff[32] ^ r_neg;
            zero0_reg <= (diff == '0) || (r_mag == '0);
            a0_reg    <= a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg   <= ua_reg * ub0_reg[31:0];
            phi_reg   <= ua_reg * ub0_reg[QW-1:32];
            neg1_reg  <= neg0_reg;
            zero1_reg <= zero0_reg;
            a1_reg    <= a0_reg;
        end
    end

    assign prod = PW'(plo_reg) + (PW'(phi_reg) << 32);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qv_reg    <= prod[SW+FB-1:FB];
            rem_reg   <= |prod[FB-1:0];
            ovf_reg   <= |prod[PW-1:SW+FB];
            neg2_reg  <= neg1_reg;
            zero2_reg <= zero1_reg;
            a2_reg    <= a1_reg;
        end
    end

    always_comb
    begin
        qadj = {1'b0, qv_reg} + (SW+1)'(neg2_reg & rem_reg);
        qs   = neg2_reg ? -{2'b00, qadj} : {2'b00, qadj};
        sum  = {{11{a2_reg[31]}}, a2_reg} + qs;
        if (zero2_reg)
        begin
            y_next = a2_reg;
        end
        else if (ovf_reg)
        begin
            y_next = neg2_reg ? bvh_pkg::INT32_MIN : bvh_pkg::INT32_MAX;
        end
        else if (sum > 43'(bvh_pkg::INT32_MAX))
        begin
            y_next = bvh_pkg::INT32_MAX;
        end
        else if (sum < 43'(bvh_pkg::INT32_MIN))
        begin
            y_next = bvh_pkg::INT32_MIN;
        end
        else
        begin
            y_next = sum[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

FILE: design/box_vs_height_patch_collision.sv
// Top level: box vs bilinear height patch collision pipeline.
// Pipeline: setup register loaded at the query transfer edge, 48 divider cells,
//   two 4-stage interpolation levels in series, 1 output register.
// Throughput: one query per cycle when not stalled; one quotient bit per divider cell.
// The whole pipeline stalls only while a result waits in the output register.
// Reset: valid bits clear, patch registers take their reset values.
module box_vs_height_patch_collision (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    query_valid,
    output logic                    query_ready,
    input  bvh_pkg::query_t         query,
    output logic                    result_valid,
    input  logic                    result_ready,
    output bvh_pkg::result_t        result,
    input  logic                    cfg_wr_en,
    input  logic [2:0]              cfg_index,
    input  logic [31:0]             cfg_data
);

    localparam int QW = bvh_pkg::Q_W;
    localparam int FB = bvh_pkg::FRAC_BITS;
    localparam int NS = bvh_pkg::DIV_STEPS;
    localparam int LL = bvh_pkg::LERP_LAT;

    logic signed [31:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic signed [31:0] h_ll_reg, h_hl_reg, h_lh_reg, h_hh_reg;

    logic en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            max_x_reg <= 32'sd65536;
            max_y_reg <= 32'sd65536;
            h_ll_reg  <= '0;
            h_hl_reg  <= '0;
            h_lh_reg  <= '0;
            h_hh_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bvh_pkg::REG_MIN_X: min_x_reg <= cfg_data;
                bvh_pkg::REG_MIN_Y: min_y_reg <= cfg_data;
                bvh_pkg::REG_MAX_X: max_x_reg <= cfg_data;
                bvh_pkg::REG_MAX_Y: max_y_reg <= cfg_data;
                bvh_pkg::REG_H_LL:  h_ll_reg  <= cfg_data;
                bvh_pkg::REG_H_HL:  h_hl_reg  <= cfg_data;
                bvh_pkg::REG_H_LH:  h_lh_reg  <= cfg_data;
                bvh_pkg::REG_H_HH:  h_hh_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en          = !result_valid || result_ready;
    assign query_ready = en;

    // setup stage
    logic [30:0]        ey, ez;
    logic signed [32:0] dx, dy, sx, sy;
    logic [32:0]        mdx, mdy, msx, msy;
    logic               in_xy;
    bvh_pkg::pl_t       front_next;

    always_comb
    begin
        ey  = query.uniform_size ? query.extent_x : query.extent_y;
        ez  = query.uniform_size ? query.extent_x : query.extent_z;
        dx  = {query.center_x[31], query.center_x} - {min_x_reg[31], min_x_reg};
        dy  = {query.center_y[31], query.center_y} - {min_y_reg[31], min_y_reg};
        sx  = {max_x_reg[31], max_x_reg} - {min_x_reg[31], min_x_reg};
        sy  = {max_y_reg[31], max_y_reg} - {min_y_reg[31], min_y_reg};
        mdx = dx[32] ? 33'(-dx) : dx;
        mdy = dy[32] ? 33'(-dy) : dy;
        msx = sx[32] ? 33'(-sx) : sx;
        msy = sy[32] ? 33'(-sy) : sy;

        in_xy = !((bvh_pkg::twice(query.center_x) + bvh_pkg::ext_extent(query.extent_x)
                        < bvh_pkg::twice(min_x_reg)) ||
                  (bvh_pkg::twice(query.center_x) - bvh_pkg::ext_extent(query.extent_x)
                        > bvh_pkg::twice(max_x_reg)) ||
                  (bvh_pkg::twice(query.center_y) + bvh_pkg::ext_extent(ey)
                        < bvh_pkg::twice(min_y_reg)) ||
                  (bvh_pkg::twice(query.center_y) - bvh_pkg::ext_extent(ey)
                        > bvh_pkg::twice(max_y_reg)));

        front_next.valid   = query_valid;
        front_next.ax.rem  = '0;
        front_next.ax.nq   = {mdx[31:0], {FB{1'b0}}};
        front_next.ax.div  = msx[31:0];
        front_next.ax.neg  = dx[32] ^ sx[32];
        front_next.ax.zero = (sx == '0);
        front_next.ay.rem  = '0;
        front_next.ay.nq   = {mdy[31:0], {FB{1'b0}}};
        front_next.ay.div  = msy[31:0];
        front_next.ay.neg  = dy[32] ^ sy[32];
        front_next.ay.zero = (sy == '0);
        front_next.cz      = query.center_z;
        front_next.ez      = ez;
        front_next.in_xy   = in_xy;
    end

    bvh_pkg::pl_t front_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else if (en)
        begin
            front_reg <= front_next;
        end
    end

    // divider chain
    bvh_pkg::pl_t chain [NS+1];

    assign chain[0] = front_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_cell
        bvh_div_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .pin  (chain[i]),
            .pout (chain[i+1])
        );
    end

    logic [QW-1:0] ry_mag;
    bvh_pkg::tag_t tag_in;

    always_comb
    begin
        ry_mag        = chain[NS].ay.zero ? '0 : chain[NS].ay.nq;
        tag_in.valid  = chain[NS].valid;
        tag_in.rx_mag = chain[NS].ax.zero ? '0 : chain[NS].ax.nq;
        tag_in.rx_neg = chain[NS].ax.neg;
        tag_in.cz     = chain[NS].cz;
        tag_in.ez     = chain[NS].ez;
        tag_in.in_xy  = chain[NS].in_xy;
    end

    // side data travelling alongside the interpolation units
    bvh_pkg::tag_t tag_reg [2*LL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2*LL; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < 2*LL; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    logic signed [31:0] z_low_x, z_high_x, z;

    bvh_lerp u_lerp_low (
        .clk  (clk),
        .en   (en),
        .a    (h_ll_reg),
        .b    (h_lh_reg),
        .r_mag(ry_mag),
        .r_neg(chain[NS].ay.neg),
        .y    (z_low_x)
    );

    bvh_lerp u_lerp_high (
        .clk  (clk),
        .en   (en),
        .a    (h_hl_reg),
        .b    (h_hh_reg),
        .r_mag(ry_mag),
        .r_neg(chain[NS].ay.neg),
        .y    (z_high_x)
    );

    bvh_lerp u_lerp_x (
        .clk  (clk),
        .en   (en),
        .a    (z_low_x),
        .b    (z_high_x),
        .r_mag(tag_reg[LL-1].rx_mag),
        .r_neg(tag_reg[LL-1].rx_neg),
        .y    (z)
    );

    // hit test and output register
    logic               hit_next;
    logic signed [33:0] z2;
    logic signed [33:0] cz2;
    logic signed [33:0] ez2;
    logic               result_valid_reg;
    bvh_pkg::result_t   result_reg;

    always_comb
    begin
        z2       = bvh_pkg::twice(z);
        cz2      = bvh_pkg::twice(tag_reg[2*LL-1].cz);
        ez2      = bvh_pkg::ext_extent(tag_reg[2*LL-1].ez);
        hit_next = tag_reg[2*LL-1].in_xy && !((cz2 + ez2 < z2) || (cz2 - ez2 > z2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= tag_reg[2*LL-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg.hit          <= hit_next;
            result_reg.floor_height <= z;
            result_reg.inside_xy    <= tag_reg[2*LL-1].in_xy;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: bench/bvh_checker.sv
`timescale 1ns / 1ps
// Checker for the box vs height patch block: predicts each query's result and compares it.
module bvh_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_valid,
    input  logic             query_ready,
    input  bvh_pkg::query_t  query,
    input  logic             result_valid,
    input  logic             result_ready,
    input  bvh_pkg::result_t result,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    output int               fail_count,
    output int               pending
);

    logic signed [31:0] patch_reg [8];
    bvh_pkg::result_t   expected_hits [$];

    function automatic longint axis_ratio(longint pos, longint lo, longint hi);
        longint span;
        span = hi - lo;
        if (span == 0)
            return 0;
        return ((pos - lo) * (longint'(1) << bvh_pkg::FRAC_BITS)) / span;
    endfunction

    // exact product in 128 bits, floor shift, clamp
    function automatic longint blend(longint a, longint b, longint r);
        logic signed [127:0] prod;
        logic signed [127:0] q;
        logic signed [127:0] s;
        prod = 128'(signed'(b - a)) * 128'(signed'(r));
        q    = prod >>> bvh_pkg::FRAC_BITS;
        s    = 128'(signed'(a)) + q;
        if (s > 128'sh7FFF_FFFF)
            return longint'(bvh_pkg::INT32_MAX);
        if (s < -128'sh8000_0000)
            return longint'(bvh_pkg::INT32_MIN);
        return longint'(s);
    endfunction

    function automatic bvh_pkg::result_t floor_contact(bvh_pkg::query_t q);
        bvh_pkg::result_t r;
        longint  cx, cy, cz, ex, ey, ez, rx, ry, zl, zh, z;
        longint  mnx, mny, mxx, mxy;
        logic    in_xy;
        mnx = patch_reg[bvh_pkg::REG_MIN_X];
        mny = patch_reg[bvh_pkg::REG_MIN_Y];
        mxx = patch_reg[bvh_pkg::REG_MAX_X];
        mxy = patch_reg[bvh_pkg::REG_MAX_Y];
        cx  = q.center_x;
        cy  = q.center_y;
        cz  = q.center_z;
        ex  = longint'(q.extent_x);
        ey  = q.uniform_size ? ex : longint'(q.extent_y);
        ez  = q.uniform_size ? ex : longint'(q.extent_z);
        in_xy = !(2*cx + ex < 2*mnx || 2*cx - ex > 2*mxx ||
                  2*cy + ey < 2*mny || 2*cy - ey > 2*mxy);
        ry = axis_ratio(cy, mny, mxy);
        rx = axis_ratio(cx, mnx, mxx);
        zl = blend(patch_reg[bvh_pkg::REG_H_LL], patch_reg[bvh_pkg::REG_H_LH], ry);
        zh = blend(patch_reg[bvh_pkg::REG_H_HL], patch_reg[bvh_pkg::REG_H_HH], ry);
        z  = blend(zl, zh, rx);
        r.inside_xy    = in_xy;
        r.floor_height = 32'(z);
        r.hit          = in_xy && !(2*cz + ez < 2*z || 2*cz - ez > 2*z);
        return r;
    endfunction

    assign pending = expected_hits.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_reg = '{0, 0, 65536, 65536, 0, 0, 0, 0};
            expected_hits.delete();
            fail_count = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("unexpected result transfer");
                    fail_count++;
                end
                else
                begin
                    bvh_pkg::result_t e;
                    e = expected_hits.pop_front();
                    if (result.hit !== e.hit)
                    begin
                        $error("hit exp %0d got %0d", e.hit, result.hit);
                        fail_count++;
                    end
                    if (result.floor_height !== e.floor_height)
                    begin
                        $error("floor_height exp %0d got %0d", e.floor_height,
                               result.floor_height);
                        fail_count++;
                    end
                    if (result.inside_xy !== e.inside_xy)
                    begin
                        $error("inside_xy exp %0d got %0d", e.inside_xy, result.inside_xy);
                        fail_count++;
                    end
                end
            end
            if (query_valid && query_ready)
                expected_hits.insert(expected_hits.size(), floor_contact(query));
            if (cfg_wr_en)
                patch_reg[cfg_index] = cfg_data;
        end
    end

endmodule

FILE: bench/tb_box_vs_height_patch_collision.sv
`timescale 1ns / 1ps
// Testbench top: drives queries and patch settings, gives the verdict.
module tb_box_vs_height_patch_collision;

    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 80;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             query_valid = 1'b0;
    logic             query_ready;
    bvh_pkg::query_t  query = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    bvh_pkg::result_t result;
    logic             cfg_wr_en = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [31:0]      cfg_data = '0;
    int               fail_count;
    int               pending;
    int               idle_cycles = 0;
    logic             calm = 1'b0;

    box_vs_height_patch_collision u_top (.*);

    bvh_checker u_chk (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((query_valid && query_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                result_ready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(posedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic settle();
        query_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic send_query(bvh_pkg::query_t q);
        int n;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            query_valid <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(posedge clk);
        end
        query_valid <= 1'b1;
        query       <= q;
        @(posedge clk);
        while (!query_ready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        endcase
    endfunction

    function automatic bvh_pkg::query_t make_query();
        bvh_pkg::query_t q;
        q.center_x     = pick32();
        q.center_y     = pick32();
        q.center_z     = pick32();
        q.extent_x     = $urandom_range(0, 3) == 0 ? 31'($urandom())
                                                   : 31'($urandom_range(0, 1 << 18));
        q.extent_y     = $urandom_range(0, 3) == 0 ? 31'($urandom())
                                                   : 31'($urandom_range(0, 1 << 18));
        q.extent_z     = $urandom_range(0, 3) == 0 ? 31'($urandom())
                                                   : 31'($urandom_range(0, 1 << 18));
        q.uniform_size = 1'($urandom_range(0, 1));
        return q;
    endfunction

    task automatic patch_setup(int mode);
        logic [31:0] lo_x, lo_y;
        lo_x = pick32();
        lo_y = pick32();
        case (mode)
            0:
            begin
                write_reg(bvh_pkg::REG_MIN_X, 32'h8000_0000);
                write_reg(bvh_pkg::REG_MIN_Y, 32'h8000_0000);
                write_reg(bvh_pkg::REG_MAX_X, 32'h7FFF_FFFF);
                write_reg(bvh_pkg::REG_MAX_Y, 32'h7FFF_FFFF);
                write_reg(bvh_pkg::REG_H_LL, 32'h8000_0000);
                write_reg(bvh_pkg::REG_H_HL, 32'h7FFF_FFFF);
                write_reg(bvh_pkg::REG_H_LH, 32'h7FFF_FFFF);
                write_reg(bvh_pkg::REG_H_HH, 32'h8000_0000);
            end
            1:
            begin
                // zero size on both axes
                write_reg(bvh_pkg::REG_MIN_X, lo_x);
                write_reg(bvh_pkg::REG_MAX_X, lo_x);
                write_reg(bvh_pkg::REG_MIN_Y, lo_y);
                write_reg(bvh_pkg::REG_MAX_Y, lo_y);
                write_reg(bvh_pkg::REG_H_LL, pick32());
                write_reg(bvh_pkg::REG_H_HL, pick32());
                write_reg(bvh_pkg::REG_H_LH, pick32());
                write_reg(bvh_pkg::REG_H_HH, pick32());
            end
            2:
            begin
                // reversed patch
                write_reg(bvh_pkg::REG_MIN_X, 32'(2 << 16));
                write_reg(bvh_pkg::REG_MAX_X, 32'(-(2 << 16)));
                write_reg(bvh_pkg::REG_MIN_Y, 32'(3 << 16));
                write_reg(bvh_pkg::REG_MAX_Y, 32'(-(1 << 16)));
                write_reg(bvh_pkg::REG_H_LL, pick32());
                write_reg(bvh_pkg::REG_H_HL, pick32());
                write_reg(bvh_pkg::REG_H_LH, pick32());
                write_reg(bvh_pkg::REG_H_HH, pick32());
            end
            default:
            begin
                write_reg(bvh_pkg::REG_MIN_X,
                          32'($signed($urandom_range(0, 6 << 16)) - (4 << 16)));
                write_reg(bvh_pkg::REG_MIN_Y,
                          32'($signed($urandom_range(0, 6 << 16)) - (4 << 16)));
                write_reg(bvh_pkg::REG_MAX_X, 32'($urandom_range(1, 6 << 16)));
                write_reg(bvh_pkg::REG_MAX_Y, 32'($urandom_range(1, 6 << 16)));
                write_reg(bvh_pkg::REG_H_LL, pick32());
                write_reg(bvh_pkg::REG_H_HL, pick32());
                write_reg(bvh_pkg::REG_H_LH, pick32());
                write_reg(bvh_pkg::REG_H_HH, pick32());
            end
        endcase
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        bvh_pkg::query_t q;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset patch: corners, edges, touching, extremes
        q = '0;
        send_query(q);
        q.center_x = 32'h0001_0000; q.center_y = 32'h0001_0000;
        send_query(q);
        q.center_x = 32'hFFFF_0000; q.extent_x = 31'h0002_0000;
        send_query(q);
        q.extent_x = 31'h0001_FFFF;
        send_query(q);
        q.center_x = 32'h8000_0000; q.center_y = 32'h7FFF_FFFF; q.center_z = 32'h8000_0000;
        q.extent_x = 31'h7FFF_FFFF; q.extent_y = 31'h7FFF_FFFF; q.extent_z = 31'h7FFF_FFFF;
        send_query(q);
        q.uniform_size = 1'b1; q.extent_y = '0; q.extent_z = '0;
        send_query(q);
        q = '0; q.center_x = 32'h0000_8000; q.center_y = 32'h0000_8000;
        q.center_z = 32'h0000_0001; q.extent_z = 31'd2;
        send_query(q);
        q.center_z = 32'h0000_0002;
        send_query(q);
        q.uniform_size = 1'b1; q.extent_x = 31'd4;
        send_query(q);

        for (int phase = 0; phase < 10; phase++)
        begin
            settle();
            patch_setup(phase < 3 ? phase : 3);
            if (phase == 0)
            begin
                q = '0; q.center_x = 32'h7FFF_FFFF; q.center_y = 32'h8000_0000;
                send_query(q);
                q.center_x = 32'h8000_0000; q.center_y = 32'h7FFF_FFFF;
                send_query(q);
            end
            calm = (phase == 9);
            for (int i = 0; i < 95; i++)
                send_query(make_query());
        end

        settle();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
design/bvh_pkg.sv
design/bvh_div_cell.sv
design/bvh_lerp.sv
design/box_vs_height_patch_collision.sv
bench/bvh_checker.sv
bench/tb_box_vs_height_patch_collision.sv
